/* hw/rtl/rmnn_pkg.sv */
// Shared types, widths and constants of the rating-matrix nearest-neighbor block.
package rmnn_pkg;

	localparam int MAX_MEMBERS_DEF = 64;
	localparam int MAX_BOOKS_DEF   = 64;

	localparam int FUNC_W   = 1;
	localparam int MEMBER_W = 6;
	localparam int BOOK_W   = 6;
	localparam int SCORE_W  = 4;
	localparam int COUNT_W  = 7;
	localparam int BSUM_W   = 13;
	localparam int PROD_W   = 8;

	localparam int SUM_LIMIT = 8191;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [FUNC_W-1:0] FUNC_STORE = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_MEMBER_COUNT = 1'b0;
	localparam logic REG_BOOK_COUNT   = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

/* hw/rtl/rmnn_if.sv */
// Item channels of the rating-matrix nearest-neighbor block: request and result.
interface rmnn_req_if import rmnn_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic [FUNC_W-1:0]          func;
	logic [MEMBER_W-1:0]        member;
	logic [BOOK_W-1:0]          book_index;
	logic signed [SCORE_W-1:0]  score;

	modport source (output valid, func, member, book_index, score, input ready);
	modport sink   (input valid, func, member, book_index, score, output ready);
endinterface

interface rmnn_rsp_if import rmnn_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [MEMBER_W-1:0]  best_member;
	logic                 found;
	logic [BSUM_W-1:0]    best_sum;

	modport source (output valid, best_member, found, best_sum, input ready);
	modport sink   (input valid, best_member, found, best_sum, output ready);
endinterface

/* hw/rtl/rating_matrix_nearest_neighbor.sv */
// Top level of the rating-matrix nearest-neighbor block: rating memory, scan engine, APB registers.
//
// The block keeps a MAX_MEMBERS x MAX_BOOKS matrix of signed 4-bit ratings in one synchronous
// memory with one write port and two read ports. After reset a clearing pass zeroes the memory,
// one entry a cycle; no item is accepted during it, while register writes are taken as usual.
// A store item is written in the cycle it is accepted. A query reads the queried row and one
// other row side by side, one book per cycle: every book below book_count for each other member
// below member_count, a pass over its own row when that row lies below member_count, then a
// drain of the read and multiply stages and the load of the output register (with no match when
// either count is zero). Its result waits in an output register while the block goes on taking
// items; a following query holds in its last cycle until that result is taken. The block works
// on one item at a time.
module rating_matrix_nearest_neighbor import rmnn_pkg::*; #(
	parameter int MAX_MEMBERS = MAX_MEMBERS_DEF,
	parameter int MAX_BOOKS   = MAX_BOOKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	rmnn_req_if.sink           req,
	rmnn_rsp_if.source         rsp
);

	localparam int DEPTH  = MAX_MEMBERS * MAX_BOOKS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ROW_W  = $clog2(MAX_MEMBERS);
	localparam int COL_W  = (MAX_BOOKS > 1) ? $clog2(MAX_BOOKS) : 1;
	localparam int SUM_W  = $clog2(64 * MAX_BOOKS + 1) + 1;

	state_t state_q, state_d;

	logic [COUNT_W-1:0] mc_q, bc_q;
	logic [COUNT_W-1:0] cfg_v;
	logic               cfg_we;

	logic [SCORE_W-1:0] mem_q [DEPTH];
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [SCORE_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]  addr_a, addr_b;

	logic [ADDR_W-1:0]  clr_q;
	logic               clr_last;

	logic                req_acc;
	logic                store_ok;
	logic [MEMBER_W-1:0] qmem_q;
	logic [COUNT_W-1:0]  i_q;
	logic [COUNT_W-1:0]  j_q;
	logic                issue_done_q;
	logic                row_is_q, skip, issue, col_last, row_last;

	logic                      v_s1, last_s1;
	logic [COUNT_W-1:0]        row_s1;
	logic signed [SCORE_W-1:0] ra_s1, rb_s1;
	logic                      v_s2, last_s2;
	logic [COUNT_W-1:0]        row_s2;
	logic signed [PROD_W-1:0]  prod_s2;

	logic signed [SUM_W-1:0] acc_q, best_q, sum_now;
	logic [COUNT_W-1:0]      best_row_q;
	logic                    found_q;

	logic out_load;
	logic out_valid_q;
	logic [MEMBER_W-1:0] out_member_q;
	logic                out_found_q;
	logic [BSUM_W-1:0]   out_sum_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign cfg_v  = pwdata[COUNT_W-1:0];
	assign prdata = (paddr[2] == REG_BOOK_COUNT) ? PDATA_W'(bc_q) : PDATA_W'(mc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mc_q <= '0;
			bc_q <= '0;
		end else if (cfg_we) begin
			case (paddr[2])
				REG_MEMBER_COUNT: mc_q <= (32'(cfg_v) > MAX_MEMBERS) ? COUNT_W'(MAX_MEMBERS) : cfg_v;
				REG_BOOK_COUNT:   bc_q <= (32'(cfg_v) > MAX_BOOKS) ? COUNT_W'(MAX_BOOKS) : cfg_v;
				default: ;
			endcase
		end
	end

	// control
	assign req_acc  = req.valid && req.ready;
	assign store_ok = (32'(req.member) < MAX_MEMBERS) && (32'(req.book_index) < MAX_BOOKS);
	assign clr_last = (clr_q == ADDR_W'(DEPTH - 1));

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && req.func == FUNC_QUERY) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (issue_done_q && !v_s1 && !v_s2) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else         state_q <= state_d;
	end

	// scan issue: one book of the queried row and of row i per cycle
	assign row_is_q = ({1'b0, qmem_q} == i_q);
	assign skip     = (state_q == ST_SCAN) && !issue_done_q && row_is_q;
	assign issue    = (state_q == ST_SCAN) && !issue_done_q && !row_is_q;
	assign col_last = (j_q == bc_q - COUNT_W'(1));
	assign row_last = (i_q == mc_q - COUNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			i_q          <= '0;
			j_q          <= '0;
			issue_done_q <= 1'b1;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (req_acc && req.func == FUNC_QUERY) begin
				i_q <= '0;
				j_q <= '0;
				// nothing to compare: finish with no match
				issue_done_q <= (mc_q == '0) || (bc_q == '0) || (32'(req.member) >= MAX_MEMBERS);
			end else if (skip || (issue && col_last)) begin
				i_q <= i_q + COUNT_W'(1);
				j_q <= '0;
				if (row_last) issue_done_q <= 1'b1;
			end else if (issue) begin
				j_q <= j_q + COUNT_W'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && req.func == FUNC_QUERY) qmem_q <= req.member;
		last_s1 <= col_last;
		row_s1  <= i_q;
		last_s2 <= last_s1;
		row_s2  <= row_s1;
		prod_s2 <= PROD_W'(ra_s1) * PROD_W'(rb_s1);
	end

	// rating memory: writes only while clearing or idle; reads are taken every cycle, used only while scanning
	assign addr_a = ADDR_W'(ADDR_W'(ROW_W'(qmem_q)) * ADDR_W'(MAX_BOOKS) + ADDR_W'(COL_W'(j_q)));
	assign addr_b = ADDR_W'(ADDR_W'(ROW_W'(i_q)) * ADDR_W'(MAX_BOOKS) + ADDR_W'(COL_W'(j_q)));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (req_acc && req.func == FUNC_STORE && store_ok) begin
			mem_we    = 1'b1;
			mem_waddr = ADDR_W'(ADDR_W'(ROW_W'(req.member)) * ADDR_W'(MAX_BOOKS)
				+ ADDR_W'(COL_W'(req.book_index)));
			mem_wdata = req.score;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		ra_s1 <= $signed(mem_q[addr_a]);
		rb_s1 <= $signed(mem_q[addr_b]);
	end

	// accumulate and keep the first strictly larger sum
	assign sum_now = acc_q + SUM_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (req_acc && req.func == FUNC_QUERY) begin
			acc_q      <= '0;
			best_q     <= '0;
			best_row_q <= '0;
			found_q    <= 1'b0;
		end else if (v_s2) begin
			if (last_s2) begin
				acc_q <= '0;
				if (sum_now > best_q) begin
					best_q     <= sum_now;
					best_row_q <= row_s2;
					found_q    <= 1'b1;
				end
			end else begin
				acc_q <= sum_now;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_member_q <= MEMBER_W'(best_row_q);
			out_found_q  <= found_q;
			out_sum_q    <= (best_q > $signed(SUM_W'(SUM_LIMIT))) ? BSUM_W'(SUM_LIMIT)
				: BSUM_W'(best_q);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.best_member = out_member_q;
	assign rsp.found       = out_found_q;
	assign rsp.best_sum    = out_sum_q;

`ifndef ASSERT_OFF
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_FINISH) |-> !mem_we)
		else $error("rating memory written during a query");

	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> state_q == ST_SCAN)
		else $error("scan pipeline busy outside a query");

	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.best_sum == '0 && rsp.best_member == '0))
		else $error("result without match carries nonzero fields");

	a_match_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.found) |-> rsp.best_sum != '0)
		else $error("result with match carries a zero sum");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten while held");
`endif

endmodule
